[hdl/plid_pkg.sv]
// Shared types and constants of the positional list block.
package plid_pkg;

    // Fixed field widths
    localparam int POS_W  = 7;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 3;

    // Default number of list entries
    localparam int DEF_CAPACITY = 64;

    // Command codes
    typedef enum logic [1:0] {
        CMD_LIST    = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_INVALID = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_BADPOS  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    // What the control path does with one accepted command
    typedef struct packed {
        t_status status;     // status of the single result (unused for a list run)
        logic    list_run;   // stream out every held entry
        logic    shift_run;  // accepted insert or delete, memory shift follows
        logic    insert;     // shift direction: 1 up (insert), 0 down (delete)
    } t_plan;

endpackage

[hdl/positional_list_insert_delete.sv]
// Top level of the positional list: command decode, list streaming, memory shift sequencer.
// A status result is registered at the edge that takes the command.
// A list streams one result per cycle after a registered RAM read, while the result port is ready;
// insert and delete move the following entries, one shift step per cycle
// through the single RAM write port.
// Reset (sync, active low) empties the list, RAM not cleared.
module positional_list_insert_delete #(
    parameter int CAPACITY = plid_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command transactions
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // result transactions
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] element, [37:32] element_index, [39:38] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast    // last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LIST  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    // Input fields
    plid_pkg::t_cmd                 in_cmd;
    logic [plid_pkg::POS_W-1:0]     in_pos;
    logic [plid_pkg::ELEM_W-1:0]    in_val;
    logic [plid_pkg::POS_W-1:0]     pos_m1;
    plid_pkg::t_plan                plan;

    assign in_cmd = plid_pkg::t_cmd'(i_s_axis_tuser);
    assign in_pos = i_s_axis_tdata[6:0];
    assign in_val = i_s_axis_tdata[38:7];
    assign pos_m1 = in_pos - 7'd1;

    // Control registers
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             r_pend, n_pend;       // list read data waiting in RAM output
    logic             r_wpend, n_wpend;     // shift read data waiting to be written
    // Sequencer payload
    logic [CW-1:0]    r_n, n_n;             // entries to list
    logic [CW-1:0]    r_rd_idx, n_rd_idx;   // next list read
    logic [AW-1:0]    r_pend_idx, n_pend_idx;
    logic [AW-1:0]    r_src, n_src;         // next shift read
    logic [CW-1:0]    r_rem, n_rem;         // shift reads left
    logic [AW-1:0]    r_wa, n_wa;
    logic             r_insert, n_insert;
    logic [AW-1:0]    r_ins_addr, n_ins_addr;
    logic [plid_pkg::ELEM_W-1:0] r_ins_val, n_ins_val;
    // Output register
    plid_pkg::t_status            r_out_status, n_out_status;
    logic [plid_pkg::ELEM_W-1:0]  r_out_elem, n_out_elem;
    logic [plid_pkg::IDX_W-1:0]   r_out_idx, n_out_idx;
    logic                         r_out_last, n_out_last;

    // RAM port signals
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [plid_pkg::ELEM_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [plid_pkg::ELEM_W-1:0] ram_rdata;

    logic in_accept;
    logic can_load;
    logic list_load;
    logic list_issue;
    logic shift_issue;
    logic shift_wb;
    logic shift_fin;

    plid_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .i_cmd      (in_cmd),
        .i_position (in_pos),
        .i_count    (r_count),
        .o_plan     (plan)
    );

    plid_ram #(
        .WIDTH (plid_pkg::ELEM_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake and step qualifiers
    assign can_load        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && can_load;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign list_load       = (r_state == S_LIST) && r_pend && can_load;
    assign list_issue      = (r_state == S_LIST) && (r_rd_idx != r_n) && (!r_pend || can_load);
    assign shift_issue     = (r_state == S_SHIFT) && (r_rem != '0);
    assign shift_wb        = (r_state == S_SHIFT) && r_wpend;
    assign shift_fin       = (r_state == S_SHIFT) && (r_rem == '0) && !r_wpend;

    // RAM access: one read and one write per cycle, never to the same entry
    always_comb begin
        ram_re    = list_issue || shift_issue;
        ram_raddr = (r_state == S_LIST) ? r_rd_idx[AW-1:0] : r_src;
        ram_we    = shift_wb || (shift_fin && r_insert);
        ram_waddr = shift_wb ? r_wa : r_ins_addr;
        ram_wdata = shift_wb ? ram_rdata : r_ins_val;
    end

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_pend       = r_pend;
        n_wpend      = r_wpend;
        n_n          = r_n;
        n_rd_idx     = r_rd_idx;
        n_pend_idx   = r_pend_idx;
        n_src        = r_src;
        n_rem        = r_rem;
        n_wa         = r_wa;
        n_insert     = r_insert;
        n_ins_addr   = r_ins_addr;
        n_ins_val    = r_ins_val;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (plan.list_run) begin
                        n_state  = S_LIST;
                        n_n      = r_count;
                        n_rd_idx = '0;
                        n_pend   = 1'b0;
                    end else begin
                        // single status result
                        n_out_valid  = 1'b1;
                        n_out_status = plan.status;
                        n_out_elem   = '0;
                        n_out_idx    = '0;
                        n_out_last   = 1'b1;
                    end
                    if (plan.shift_run) begin
                        n_state    = S_SHIFT;
                        n_insert   = plan.insert;
                        n_wpend    = 1'b0;
                        n_ins_addr = pos_m1[AW-1:0];
                        n_ins_val  = in_val;
                        if (plan.insert) begin
                            n_count = r_count + CW'(1);
                            n_src   = AW'(r_count - CW'(1));
                            n_rem   = r_count - CW'(in_pos) + CW'(1);
                        end else begin
                            n_count = r_count - CW'(1);
                            n_src   = in_pos[AW-1:0];
                            n_rem   = r_count - CW'(in_pos);
                        end
                    end
                end
            end
            S_LIST: begin
                if (list_load) begin
                    n_pend       = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_status = plid_pkg::ST_OK;
                    n_out_elem   = ram_rdata;
                    n_out_idx    = plid_pkg::IDX_W'(r_pend_idx);
                    n_out_last   = (CW'(r_pend_idx) + CW'(1) == r_n);
                end
                if (list_issue) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                end
                if ((r_rd_idx == r_n) && (!r_pend || list_load)) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                n_wpend = 1'b0;
                if (shift_issue) begin
                    n_wpend = 1'b1;
                    n_wa    = r_insert ? r_src + AW'(1) : r_src - AW'(1);
                    n_src   = r_insert ? r_src - AW'(1) : r_src + AW'(1);
                    n_rem   = r_rem - CW'(1);
                end
                if (shift_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_wpend     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_wpend     <= n_wpend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_rd_idx     <= n_rd_idx;
        r_pend_idx   <= n_pend_idx;
        r_src        <= n_src;
        r_rem        <= n_rem;
        r_wa         <= n_wa;
        r_insert     <= n_insert;
        r_ins_addr   <= n_ins_addr;
        r_ins_val    <= n_ins_val;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    // Result port
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_idx, r_out_elem};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SHIFT))
        else $error("entry write outside shift sequence");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_rd_idx <= r_n))
        else $error("list read index ran past entry count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same entry in one cycle");

endmodule

[hdl/plid_ram.sv]
// Generic simple dual-port RAM with registered read and read enable.
module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/plid_decode.sv]
// Command decoder: position checks against the entry count and the result status.
module plid_decode #(
    parameter int CAPACITY = plid_pkg::DEF_CAPACITY
) (
    input  plid_pkg::t_cmd                  i_cmd,
    input  logic [plid_pkg::POS_W-1:0]      i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_count,
    output plid_pkg::t_plan                 o_plan
);

    logic [7:0] cnt8;
    logic [7:0] pos8;
    logic       pos_zero;
    logic       ins_ok;
    logic       del_ok;
    logic       full;

    assign cnt8     = 8'(i_count);
    assign pos8     = {1'b0, i_position};
    assign pos_zero = (i_position == '0);
    assign ins_ok   = !pos_zero && (pos8 <= cnt8 + 8'd1);
    assign del_ok   = !pos_zero && (pos8 <= cnt8);
    assign full     = (cnt8 == 8'(CAPACITY));

    always_comb begin
        o_plan = '{status: plid_pkg::ST_OK, list_run: 1'b0, shift_run: 1'b0,
                   insert: 1'b0};
        unique case (i_cmd)
            plid_pkg::CMD_LIST: begin
                if (i_count == '0) begin
                    o_plan.status = plid_pkg::ST_EMPTY;
                end else begin
                    o_plan.list_run = 1'b1;
                end
            end
            plid_pkg::CMD_INSERT: begin
                // position is checked before fullness
                if (!ins_ok) begin
                    o_plan.status = plid_pkg::ST_BADPOS;
                end else if (full) begin
                    o_plan.status = plid_pkg::ST_FULL;
                end else begin
                    o_plan.shift_run = 1'b1;
                    o_plan.insert    = 1'b1;
                end
            end
            plid_pkg::CMD_DELETE: begin
                if (!del_ok) begin
                    o_plan.status = plid_pkg::ST_BADPOS;
                end else begin
                    o_plan.shift_run = 1'b1;
                end
            end
            plid_pkg::CMD_INVALID: begin
                o_plan.status = plid_pkg::ST_UNKNOWN;
            end
            default: begin
                o_plan.status = plid_pkg::ST_UNKNOWN;
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the positional list: directed and random command streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = plid_pkg::DEF_CAPACITY;
    localparam int POS_W      = plid_pkg::POS_W;
    localparam int ELEM_W     = plid_pkg::ELEM_W;
    localparam int IDX_W      = plid_pkg::IDX_W;
    localparam int STAT_W     = plid_pkg::STAT_W;
    localparam int RAND_ITEMS = 136;
    localparam int HOLD_LEN   = 300;
    localparam int CYCLE_MAX  = 500000;

    // Predicted list contents and the queue of results still owed by the block
    class list_scoreboard;
        typedef struct {
            plid_pkg::t_status        status;
            logic signed [ELEM_W-1:0] element;
            logic [IDX_W-1:0]         index;
            logic                     last;
        } t_result;

        logic signed [ELEM_W-1:0] cells [CAP];
        int unsigned              count;
        t_result                  owed_q [$];
        int                       errors;

        function new();
            count  = 0;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void owe(plid_pkg::t_status st, logic signed [ELEM_W-1:0] el,
                          logic [IDX_W-1:0] ix, logic lst);
            t_result r;
            r.status  = st;
            r.element = el;
            r.index   = ix;
            r.last    = lst;
            owed_q.push_back(r);
        endfunction

        // Apply one accepted command to the shadow list, queue its results
        function void note_command(plid_pkg::t_cmd c, logic [POS_W-1:0] pos,
                                   logic signed [ELEM_W-1:0] val);
            int unsigned i;
            case (c)
                plid_pkg::CMD_LIST: begin
                    if (count == 0)
                        owe(plid_pkg::ST_EMPTY, '0, '0, 1'b1);
                    else
                        for (i = 0; i < count; i++)
                            owe(plid_pkg::ST_OK, cells[i], i[IDX_W-1:0], (i + 1 == count));
                end
                plid_pkg::CMD_INSERT: begin
                    // position is checked before fullness
                    if (pos < 1 || pos > count + 1) begin
                        owe(plid_pkg::ST_BADPOS, '0, '0, 1'b1);
                    end else if (count >= CAP) begin
                        owe(plid_pkg::ST_FULL, '0, '0, 1'b1);
                    end else begin
                        for (i = count; i >= pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos-1] = val;
                        count++;
                        owe(plid_pkg::ST_OK, '0, '0, 1'b1);
                    end
                end
                plid_pkg::CMD_DELETE: begin
                    if (pos < 1 || pos > count) begin
                        owe(plid_pkg::ST_BADPOS, '0, '0, 1'b1);
                    end else begin
                        for (i = pos - 1; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                        owe(plid_pkg::ST_OK, '0, '0, 1'b1);
                    end
                end
                default: owe(plid_pkg::ST_UNKNOWN, '0, '0, 1'b1);
            endcase
        endfunction

        // Compare one result transaction against the oldest owed result
        function void check_result(logic [STAT_W-1:0] st, logic [ELEM_W-1:0] el,
                                   logic [IDX_W-1:0] ix, logic lst);
            t_result r;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d element %0d index %0d last %0b",
                         $time, st, $signed(el), ix, lst);
                return;
            end
            r = owed_q.pop_front();
            if (st !== r.status || el !== r.element || ix !== r.index || lst !== r.last) begin
                errors++;
                $display("%0t: mismatch: expected status %0d element %0d index %0d last %0b",
                         $time, r.status, r.element, r.index, r.last);
                $display("%0t:           got      status %0d element %0d index %0d last %0b",
                         $time, st, $signed(el), ix, lst);
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;  // [6:0] position, [38:7] value, [39] zero
    logic [1:0]  i_s_axis_tuser  = '0;  // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [31:0] element, [37:32] element_index, [39:38] zero
    logic [2:0]  o_m_axis_tuser;        // [2:0] status
    logic        o_m_axis_tlast;

    list_scoreboard sb = new();
    int             src_idle_pct   = 0;
    int             sink_stall_pct = 0;
    int             list_len       = 0;  // list length as the stimulus sees it
    logic           sink_hold      = 1'b0;
    int             cycle_cnt      = 0;
    event           hold_off_ev;

    positional_list_insert_delete #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Long receiver hold-off, counted here
    always begin
        @(hold_off_ev);
        sink_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Transaction monitor: commands first, then results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_command(plid_pkg::t_cmd'(i_s_axis_tuser), i_s_axis_tdata[6:0],
                                i_s_axis_tdata[38:7]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tuser, o_m_axis_tdata[31:0],
                                o_m_axis_tdata[37:32], o_m_axis_tlast);
        end
    end

    // Offer one command transaction; returns at the edge that accepts it
    task automatic send_cmd(input plid_pkg::t_cmd c, input int pos,
                            input logic [ELEM_W-1:0] val, input int len_delta);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, val, POS_W'(pos)};
        i_s_axis_tuser  <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        list_len += len_delta;
    endtask

    // One random command, biased toward filling or draining the list
    task automatic send_random(input bit grow);
        int r;
        r = $urandom_range(99);
        if (r < 7) begin
            send_cmd(plid_pkg::CMD_LIST, $urandom_range(127), $urandom, 0);
        end else if (r < 15) begin
            // noise: unknown command or out-of-range positions
            case ($urandom_range(2))
                0: send_cmd(plid_pkg::CMD_INVALID, $urandom_range(127), $urandom, 0);
                1: send_cmd(plid_pkg::CMD_INSERT, $urandom_range(3) == 0 ? 0 :
                            $urandom_range(127, list_len + 2), $urandom, 0);
                default: send_cmd(plid_pkg::CMD_DELETE, $urandom_range(3) == 0 ? 0 :
                                  $urandom_range(127, list_len + 1), $urandom, 0);
            endcase
        end else if (grow ? r < 95 : r < 20) begin
            send_cmd(plid_pkg::CMD_INSERT, $urandom_range(list_len + 1, 1), $urandom,
                     (list_len < CAP) ? 1 : 0);
        end else if (list_len > 0) begin
            send_cmd(plid_pkg::CMD_DELETE, $urandom_range(list_len, 1), $urandom, -1);
        end else begin
            send_cmd(plid_pkg::CMD_DELETE, 1, $urandom, 0);
        end
    endtask

    initial begin
        bit grow;
        int n;
        grow = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, bad positions, extreme values, every command
        send_cmd(plid_pkg::CMD_LIST,    0,   $urandom, 0);
        send_cmd(plid_pkg::CMD_DELETE,  1,   $urandom, 0);
        send_cmd(plid_pkg::CMD_DELETE,  0,   $urandom, 0);
        send_cmd(plid_pkg::CMD_INSERT,  0,   $urandom, 0);
        send_cmd(plid_pkg::CMD_INSERT,  2,   $urandom, 0);
        send_cmd(plid_pkg::CMD_INSERT,  1,   32'h7FFF_FFFF, 1);
        send_cmd(plid_pkg::CMD_INSERT,  2,   32'h8000_0000, 1);
        send_cmd(plid_pkg::CMD_INSERT,  1,   32'h0000_0000, 1);
        send_cmd(plid_pkg::CMD_INSERT,  2,   32'hFFFF_FFFF, 1);
        send_cmd(plid_pkg::CMD_INSERT,  127, $urandom, 0);
        send_cmd(plid_pkg::CMD_LIST,    127, $urandom, 0);
        send_cmd(plid_pkg::CMD_DELETE,  5,   $urandom, 0);
        send_cmd(plid_pkg::CMD_DELETE,  4,   $urandom, -1);
        send_cmd(plid_pkg::CMD_DELETE,  1,   $urandom, -1);
        send_cmd(plid_pkg::CMD_INVALID, 127, $urandom, 0);
        send_cmd(plid_pkg::CMD_INVALID, 0,   32'h0, 0);
        send_cmd(plid_pkg::CMD_LIST,    0,   $urandom, 0);
        send_cmd(plid_pkg::CMD_DELETE,  1,   $urandom, -1);
        send_cmd(plid_pkg::CMD_DELETE,  1,   $urandom, -1);
        send_cmd(plid_pkg::CMD_LIST,    0,   $urandom, 0);
        send_cmd(plid_pkg::CMD_INSERT,  1,   32'h5555_5555, 1);
        send_cmd(plid_pkg::CMD_INSERT,  1,   32'hAAAA_AAAA, 1);
        send_cmd(plid_pkg::CMD_LIST,    0,   $urandom, 0);

        // Random: fill to capacity, probe the full list, then drain
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % (RAND_ITEMS / 4) == 0) begin
                case (n / (RAND_ITEMS / 4))
                    0: begin
                        src_idle_pct   <= 0;
                        sink_stall_pct <= 0;
                        -> hold_off_ev;
                    end
                    1: begin
                        src_idle_pct   <= 74;
                        sink_stall_pct <= 0;
                    end
                    2: begin
                        src_idle_pct   <= 0;
                        sink_stall_pct <= 74;
                    end
                    default: begin
                        src_idle_pct   <= 23;
                        sink_stall_pct <= 23;
                    end
                endcase
            end
            if (grow && list_len == CAP) begin
                // full list: valid position reports full, beyond the end is a bad position
                send_cmd(plid_pkg::CMD_INSERT, $urandom_range(CAP + 1, 1), $urandom, 0);
                send_cmd(plid_pkg::CMD_INSERT, $urandom_range(127, CAP + 2), $urandom, 0);
                send_cmd(plid_pkg::CMD_LIST, $urandom_range(127), $urandom, 0);
                grow = 1'b0;
            end else begin
                if (!grow && list_len == 0)
                    grow = 1'b1;
                send_random(grow);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // Drain, then allow for any stray result
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (sb.owed_q.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.owed_q.size());
        end
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
